// File: rtl/pfsp_pkg.sv
// ============================================================================
// pfsp_pkg
// Shared types, codes and helpers for the pixel frame stream parser.
// ============================================================================
package pfsp_pkg;

    localparam logic [8:0] MAX_GRID_DIM  = 9'd64;
    localparam int         Q_DEPTH       = 2;
    localparam logic [7:0] DEFAULT_RATE  = 8'd30;
    localparam logic [6:0] RESET_WIDTH   = 7'd32;
    localparam logic [6:0] RESET_HEIGHT  = 7'd16;
    localparam logic [6:0] ROW_SAT       = 7'd127;

    typedef enum logic [1:0] {
        EV_HEADER     = 2'd0,
        EV_PIXEL      = 2'd1,
        EV_BAD_MAGIC  = 2'd2,
        EV_FRAME_DONE = 2'd3
    } t_event;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } t_in;

    typedef struct packed {
        logic [1:0] event_res;
        logic [7:0] frame_rate;
        logic [5:0] row;
        logic [5:0] column;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       end_of_frame;
    } t_out;

    typedef struct packed {
        t_event     evt;
        logic [7:0] rate;
        logic [5:0] row;
        logic [5:0] column;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       eof;
    } t_cmd;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0:    m = 8'h4F;
            2'd1:    m = 8'h50;
            default: m = 8'h43;
        endcase
        return m;
    endfunction

    function automatic logic [6:0] clamp_dim(input logic [6:0] v);
        logic [6:0] d;
        if (v == 7'd0) begin
            d = 7'd1;
        end else if ({2'b00, v} > MAX_GRID_DIM) begin
            d = MAX_GRID_DIM[6:0];
        end else begin
            d = v;
        end
        return d;
    endfunction

    function automatic logic [6:0] row_inc(input logic [6:0] r);
        return (r < ROW_SAT) ? r + 7'd1 : r;
    endfunction

endpackage

// File: rtl/pixel_frame_stream_parser.sv
// ============================================================================
// pixel_frame_stream_parser
// Byte-stream parser for pixel animation files with an APB grid setup port.
// ============================================================================
// Throughput: one byte per cycle while the queue is not full; the parser step
// is combinational. A result is written into the queue at the edge that takes
// its byte and then into the output register once that is free; downstream
// stalls back up into the queue and then into the input ready.
// Reset: synchronous active-low; clears parser, queue, output valid, sets
// frame rate to 30 and grid to 32 x 16.
module pixel_frame_stream_parser
    import pfsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = Q_DEPTH
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    logic [6:0] r_grid_width;
    logic [6:0] r_grid_height;
    logic       q_full, q_empty, q_push, q_pop;
    t_cmd       f_cmd, q_cmd;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= RESET_WIDTH;
            r_grid_height <= RESET_HEIGHT;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_GRID_WIDTH:  r_grid_width  <= pwdata[6:0];
                REG_GRID_HEIGHT: r_grid_height <= pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = 32'd0;
        unique case (paddr[2])
            REG_GRID_WIDTH:  prdata = {25'd0, r_grid_width};
            REG_GRID_HEIGHT: prdata = {25'd0, r_grid_height};
            default: begin
            end
        endcase
    end

    pfsp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_grid_width  (r_grid_width),
        .i_grid_height (r_grid_height),
        .i_valid       (i_valid),
        .i_data        (i_data),
        .o_ready       (o_ready),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_cmd         (f_cmd)
    );

    pfsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    pfsp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (q_cmd),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );

endmodule

// File: rtl/pfsp_front.sv
// ============================================================================
// pfsp_front
// Byte parser: tracks file/frame headers and payload, builds result commands.
// ============================================================================
module pfsp_front
    import pfsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [6:0] i_grid_width,
    input  logic [6:0] i_grid_height,
    input  logic       i_valid,
    input  t_in        i_data,
    output logic       o_ready,
    input  logic       i_q_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        PH_FILE_HDR,
        PH_FRAME_HDR,
        PH_PAYLOAD,
        PH_ERROR
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_hc, n_hc;
    logic [7:0]  r_len_hi, n_len_hi;
    logic [15:0] r_rem, n_rem;
    logic [1:0]  r_tc, n_tc;
    logic [7:0]  r_red, n_red;
    logic [7:0]  r_green, n_green;
    logic [6:0]  r_row, n_row;
    logic [6:0]  r_col, n_col;

    t_phase      e_phase;
    logic [1:0]  e_hc;
    logic [7:0]  e_len_hi;
    logic [15:0] e_rem;
    logic [1:0]  e_tc;
    logic [6:0]  e_row, e_col;
    logic [6:0]  w, h;
    logic [6:0] r0, c0, c1;
    logic [7:0]  b;
    logic        last, emit, accept;
    t_cmd        cmd;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && emit;
    assign o_cmd   = cmd;

    always_comb begin
        w  = clamp_dim(i_grid_width);
        h  = clamp_dim(i_grid_height);
        b  = i_data.data_byte;

        e_phase  = i_data.file_start ? PH_FILE_HDR : r_phase;
        e_hc     = i_data.file_start ? 2'd0 : r_hc;
        e_len_hi = i_data.file_start ? 8'd0 : r_len_hi;
        e_rem    = i_data.file_start ? 16'd0 : r_rem;
        e_tc     = i_data.file_start ? 2'd0 : r_tc;
        e_row    = i_data.file_start ? 7'd0 : r_row;
        e_col    = i_data.file_start ? 7'd0 : r_col;

        n_phase  = e_phase;
        n_hc     = e_hc;
        n_len_hi = e_len_hi;
        n_rem    = e_rem;
        n_tc     = e_tc;
        n_red    = r_red;
        n_green  = r_green;
        n_row    = e_row;
        n_col    = e_col;

        last = 1'b0;
        r0   = e_row;
        c0   = e_col;
        c1   = 7'd0;
        emit = 1'b0;
        cmd  = '0;
        cmd.evt = EV_HEADER;

        unique case (e_phase)
            PH_FILE_HDR: begin
                if (e_hc != 2'd3) begin
                    if (b != magic_byte(e_hc)) begin
                        n_phase = PH_ERROR;
                        n_hc    = 2'd0;
                        emit    = 1'b1;
                        cmd.evt = EV_BAD_MAGIC;
                    end else begin
                        n_hc = e_hc + 2'd1;
                    end
                end else begin
                    n_hc     = 2'd0;
                    n_phase  = PH_FRAME_HDR;
                    emit     = 1'b1;
                    cmd.evt  = EV_HEADER;
                    cmd.rate = (b == 8'd0) ? DEFAULT_RATE : b;
                end
            end
            PH_FRAME_HDR: begin
                if (e_hc != 2'd3) begin
                    if (e_hc == 2'd2) begin
                        n_len_hi = b;
                    end
                    n_hc = e_hc + 2'd1;
                end else begin
                    n_hc  = 2'd0;
                    n_rem = {e_len_hi, b};
                    n_tc  = 2'd0;
                    n_row = 7'd0;
                    n_col = 7'd0;
                    if ({e_len_hi, b} == 16'd0) begin
                        emit    = 1'b1;
                        cmd.evt = EV_FRAME_DONE;
                        cmd.eof = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_rem = e_rem - 16'd1;
                last  = (e_rem == 16'd1);
                if (last) begin
                    n_phase = PH_FRAME_HDR;
                end
                if (e_tc == 2'd0) begin
                    n_red = b;
                    n_tc  = 2'd1;
                end else if (e_tc == 2'd1) begin
                    n_green = b;
                    n_tc    = 2'd2;
                end else begin
                    n_tc = 2'd0;
                    if (e_col >= w) begin
                        c0 = 7'd0;
                        r0 = row_inc(e_row);
                    end
                    c1 = c0 + 7'd1;
                    if (c1 >= w) begin
                        n_col = 7'd0;
                        n_row = row_inc(r0);
                    end else begin
                        n_col = c1;
                        n_row = r0;
                    end
                    if (r0 < h) begin
                        emit       = 1'b1;
                        cmd.evt    = EV_PIXEL;
                        cmd.row    = r0[5:0];
                        cmd.column = c0[5:0];
                        cmd.red    = r_red;
                        cmd.green  = r_green;
                        cmd.blue   = b;
                        cmd.eof    = last;
                    end
                end
                if (last) begin
                    n_tc = 2'd0;
                    if (!emit) begin
                        emit    = 1'b1;
                        cmd.evt = EV_FRAME_DONE;
                        cmd.eof = 1'b1;
                    end
                end
            end
            PH_ERROR: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FILE_HDR;
            r_hc     <= 2'd0;
            r_len_hi <= 8'd0;
            r_rem    <= 16'd0;
            r_tc     <= 2'd0;
            r_red    <= 8'd0;
            r_green  <= 8'd0;
            r_row    <= 7'd0;
            r_col    <= 7'd0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_hc     <= n_hc;
            r_len_hi <= n_len_hi;
            r_rem    <= n_rem;
            r_tc     <= n_tc;
            r_red    <= n_red;
            r_green  <= n_green;
            r_row    <= n_row;
            r_col    <= n_col;
        end
    end

endmodule

// File: rtl/pfsp_queue.sv
// ============================================================================
// pfsp_queue
// Small FIFO decoupling the parser from the output stage.
// ============================================================================
module pfsp_queue
    import pfsp_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue pop while empty");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue count out of step");
`endif

endmodule

// File: rtl/pfsp_back.sv
// ============================================================================
// pfsp_back
// Output stage: stamps the frame rate onto each result and holds it for transfer.
// ============================================================================
module pfsp_back
    import pfsp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_empty,
    input  t_cmd i_cmd,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    logic       r_valid;
    t_out       r_out;
    logic [7:0] r_rate;
    logic [7:0] rate_now;

    assign o_pop    = !i_q_empty && (!r_valid || i_ready);
    assign rate_now = (i_cmd.evt == EV_HEADER) ? i_cmd.rate : r_rate;
    assign o_valid  = r_valid;
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rate  <= DEFAULT_RATE;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_rate  <= rate_now;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.event_res    <= i_cmd.evt;
            r_out.frame_rate   <= rate_now;
            r_out.row          <= i_cmd.row;
            r_out.column       <= i_cmd.column;
            r_out.red          <= i_cmd.red;
            r_out.green        <= i_cmd.green;
            r_out.blue         <= i_cmd.blue;
            r_out.end_of_frame <= i_cmd.eof;
        end
    end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pixel frame stream parser. A short table of
// hand-picked bytes runs first, then whole random animation files, broken
// headers and noise under several grid sizes set over APB. Results are
// checked against pinned rows or a predictor kept in step with each accepted byte.
// ----------------------------------------------------------------------------
module tb_top;
    import pfsp_pkg::*;

    localparam logic [2:0] ADDR_WIDTH  = 3'd0;
    localparam logic [2:0] ADDR_HEIGHT = 3'd4;
    localparam logic [7:0] CH_O        = 8'h4F;
    localparam logic [7:0] CH_P        = 8'h50;
    localparam logic [7:0] CH_C        = 8'h43;
    localparam int         N_GRIDS     = 8;
    localparam int         PHASE_BYTES = 10;
    localparam int         HOLD_CYCLES = 400;
    localparam int         MAX_CYCLES  = 400000;

    typedef enum logic [1:0] {
        PH_FILE_HDR,
        PH_FRAME_HDR,
        PH_PAYLOAD,
        PH_HALT
    } t_phase;

    typedef struct {
        t_in  item;
        bit   pin;
        t_out res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in         i_data;
    logic        o_valid;
    logic        i_ready;
    t_out        o_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic        pin_q;
    t_out        pin_res;

    logic [7:0]  magic_seq [3] = '{CH_O, CH_P, CH_C};
    logic [6:0]  grid_w [N_GRIDS] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd5, 7'd64, 7'd1, 7'd7};
    logic [6:0]  grid_h [N_GRIDS] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd3, 7'd1, 7'd64, 7'd9};

    // predictor state
    logic [6:0]  cfg_width;
    logic [6:0]  cfg_height;
    t_phase      st_phase;
    int          st_hdr_cnt;
    logic [7:0]  st_len_hi;
    logic [15:0] st_remain;
    int          st_trip;
    logic [7:0]  st_red;
    logic [7:0]  st_green;
    int          st_row;
    int          st_col;
    logic [7:0]  st_rate;

    t_out        event_q [$];
    t_row        dir_rows [$];
    int          err_cnt;
    int          live_bytes;
    int          cycles;
    int          tail_bytes;
    bit          tx_gaps;
    bit          rx_gaps;
    bit          hold_req;

    pixel_frame_stream_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int grid_dim(input logic [6:0] v);
        int d;
        d = v;
        if (d < 1) d = 1;
        if (d > int'(MAX_GRID_DIM)) d = int'(MAX_GRID_DIM);
        return d;
    endfunction

    function automatic bit parse_byte(input t_in it, output t_out res);
        int         w;
        int         h;
        int         r;
        int         c;
        bit         last;
        bit         has;
        logic [7:0] b;
        w = grid_dim(cfg_width);
        h = grid_dim(cfg_height);
        b = it.data_byte;
        res = '0;
        has = 1'b0;
        if (it.file_start) begin
            st_phase = PH_FILE_HDR;
            st_hdr_cnt = 0;
            st_len_hi = '0;
            st_remain = '0;
            st_trip = 0;
            st_row = 0;
            st_col = 0;
        end
        case (st_phase)
            PH_FILE_HDR: begin
                if (st_hdr_cnt < 3) begin
                    if (b != magic_seq[st_hdr_cnt]) begin
                        st_phase = PH_HALT;
                        st_hdr_cnt = 0;
                        has = 1'b1;
                        res.event_res = EV_BAD_MAGIC;
                    end else begin
                        st_hdr_cnt++;
                    end
                end else begin
                    st_rate = (b == 8'd0) ? DEFAULT_RATE : b;
                    st_hdr_cnt = 0;
                    st_phase = PH_FRAME_HDR;
                    has = 1'b1;
                    res.event_res = EV_HEADER;
                end
            end
            PH_FRAME_HDR: begin
                if (st_hdr_cnt < 3) begin
                    if (st_hdr_cnt == 2) st_len_hi = b;
                    st_hdr_cnt++;
                end else begin
                    st_hdr_cnt = 0;
                    st_remain = {st_len_hi, b};
                    st_trip = 0;
                    st_row = 0;
                    st_col = 0;
                    if (st_remain == 16'd0) begin
                        has = 1'b1;
                        res.event_res = EV_FRAME_DONE;
                        res.end_of_frame = 1'b1;
                    end else begin
                        st_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                st_remain = st_remain - 16'd1;
                last = (st_remain == 16'd0);
                if (last) st_phase = PH_FRAME_HDR;
                if (st_trip == 0) begin
                    st_red = b;
                    st_trip = 1;
                end else if (st_trip == 1) begin
                    st_green = b;
                    st_trip = 2;
                end else begin
                    st_trip = 0;
                    if (st_col >= w) begin
                        st_col = 0;
                        if (st_row < 127) st_row++;
                    end
                    r = st_row;
                    c = st_col;
                    st_col++;
                    if (st_col >= w) begin
                        st_col = 0;
                        if (st_row < 127) st_row++;
                    end
                    if (r < h) begin
                        has = 1'b1;
                        res.event_res = EV_PIXEL;
                        res.row = r[5:0];
                        res.column = c[5:0];
                        res.red = st_red;
                        res.green = st_green;
                        res.blue = b;
                        res.end_of_frame = last;
                    end
                end
                if (last) begin
                    st_trip = 0;
                    if (!has) begin
                        has = 1'b1;
                        res.event_res = EV_FRAME_DONE;
                        res.end_of_frame = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.frame_rate = st_rate;
        return has;
    endfunction

    task automatic log_fault(input string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("%s", msg);
    endtask

    // input transfers feed the predictor
    always @(posedge i_clk) begin : accept_proc
        t_out res;
        bit   has;
        if (i_rst_n && i_valid && o_ready) begin
            if (st_phase != PH_HALT || i_data.file_start) live_bytes++;
            has = parse_byte(i_data, res);
            if (pin_q) begin
                event_q.push_back(pin_res);
            end else if (has) begin
                event_q.push_back(res);
            end
        end
    end

    always @(posedge i_clk) begin : check_proc
        t_out want;
        t_out got;
        if (i_rst_n && o_valid && i_ready) begin
            got = o_data;
            if (event_q.size() == 0) begin
                log_fault($sformatf("result with nothing expected: ev=%0d", got.event_res));
            end else begin
                want = event_q.pop_front();
                if (got.event_res !== want.event_res || got.frame_rate !== want.frame_rate ||
                    got.row !== want.row || got.column !== want.column ||
                    got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.end_of_frame !== want.end_of_frame) begin
                    log_fault({
                        $sformatf("mismatch exp ev=%0d fr=%0d r=%0d c=%0d rgb=%h%h%h eof=%0d",
                                  want.event_res, want.frame_rate, want.row, want.column,
                                  want.red, want.green, want.blue, want.end_of_frame),
                        $sformatf(" | got ev=%0d fr=%0d r=%0d c=%0d rgb=%h%h%h eof=%0d",
                                  got.event_res, got.frame_rate, got.row, got.column,
                                  got.red, got.green, got.blue, got.end_of_frame)});
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > MAX_CYCLES) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin : rx_proc
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) begin
                    i_ready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            i_ready <= !(rx_gaps && $urandom_range(99) < 34);
        end
    end

    task automatic send(input t_in it, input bit pin, input t_out typed);
        while (tx_gaps && $urandom_range(99) < 34) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        pin_q <= pin;
        pin_res <= typed;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b, input bit fs);
        send(t_in'{b, fs}, 1'b0, '0);
    endtask

    task automatic add_row(input logic [7:0] b, input bit fs, input bit pin = 1'b0,
                           input t_event ev = EV_HEADER, input logic [7:0] rate = 8'd0,
                           input bit eof = 1'b0);
        t_row row;
        row.item = t_in'{b, fs};
        row.pin = pin;
        row.res = '0;
        row.res.event_res = ev;
        row.res.frame_rate = rate;
        row.res.end_of_frame = eof;
        dir_rows.push_back(row);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (event_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [6:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {25'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr == ADDR_WIDTH) cfg_width = value;
        else cfg_height = value;
        // read back
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {25'd0, value}) begin
            log_fault($sformatf("readback addr %0d: exp %h got %h", addr, value, prdata));
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_file_header(input logic [7:0] rate);
        send_byte(CH_O, 1'b1);
        send_byte(CH_P, 1'b0);
        send_byte(CH_C, 1'b0);
        send_byte(rate, 1'b0);
    endtask

    task automatic send_file();
        int          k;
        int          len;
        int          kind;
        int          cells;
        logic [15:0] len16;
        if ($urandom_range(9) == 0) begin
            k = $urandom_range(0, 2);
            for (int i = 0; i < k; i++) send_byte(magic_seq[i], i == 0);
            send_byte(magic_seq[k] ^ 8'($urandom_range(1, 255)), k == 0);
            repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(255)), 1'b0);
            return;
        end
        send_file_header(($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255)));
        repeat ($urandom_range(1, 3)) begin
            send_byte(8'($urandom_range(255)), 1'b0);
            send_byte(8'($urandom_range(255)), 1'b0);
            kind = $urandom_range(99);
            cells = grid_dim(cfg_width) * grid_dim(cfg_height);
            if (kind < 10) len = 0;
            else if (kind < 60) len = 3 * $urandom_range(1, 12);
            else if (kind < 75) len = $urandom_range(1, 40);
            else if (kind < 88) len = (3 * cells + 9 <= 400) ?
                                      3 * cells + $urandom_range(0, 9) :
                                      $urandom_range(100, 400);
            else if (kind < 95) len = 256 + $urandom_range(0, 150);
            else begin
                // huge length, cut short by the next file start
                send_byte(8'($urandom_range(1, 255)), 1'b0);
                send_byte(8'($urandom_range(255)), 1'b0);
                repeat ($urandom_range(2, 20)) send_byte(8'($urandom_range(255)), 1'b0);
                return;
            end
            len16 = 16'(len);
            send_byte(len16[15:8], 1'b0);
            send_byte(len16[7:0], 1'b0);
            repeat (len) send_byte(8'($urandom_range(255)), 1'b0);
        end
    endtask

    initial begin : main_proc
        int goal;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data <= '0;
        pin_q <= 1'b0;
        pin_res <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        cfg_width = RESET_WIDTH;
        cfg_height = RESET_HEIGHT;
        st_phase = PH_FILE_HDR;
        st_hdr_cnt = 0;
        st_len_hi = '0;
        st_remain = '0;
        st_trip = 0;
        st_red = '0;
        st_green = '0;
        st_row = 0;
        st_col = 0;
        st_rate = DEFAULT_RATE;
        err_cnt = 0;
        live_bytes = 0;
        cycles = 0;
        tail_bytes = 0;
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        hold_req = 1'b0;

        add_row(CH_O, 1'b1);
        add_row(CH_P, 1'b0);
        add_row(CH_C, 1'b0);
        add_row(8'h00, 1'b0, 1'b1, EV_HEADER, 8'd30);
        add_row(8'hA5, 1'b0);
        add_row(8'h5A, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0, 1'b1, EV_FRAME_DONE, 8'd30, 1'b1);
        add_row(8'hFF, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h05, 1'b0);
        add_row(8'hFF, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h80, 1'b0);
        add_row(8'h11, 1'b0);
        add_row(8'h22, 1'b0, 1'b1, EV_FRAME_DONE, 8'd30, 1'b1);
        add_row(CH_O, 1'b1);
        add_row(CH_P, 1'b0);
        add_row(CH_C, 1'b0);
        add_row(8'hFF, 1'b0, 1'b1, EV_HEADER, 8'd255);
        add_row(8'hB0, 1'b1, 1'b1, EV_BAD_MAGIC, 8'd255);
        add_row(CH_O, 1'b0);
        add_row(CH_O, 1'b1);
        add_row(CH_P, 1'b0);
        add_row(8'h42, 1'b0, 1'b1, EV_BAD_MAGIC, 8'd255);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) send(dir_rows[i].item, dir_rows[i].pin, dir_rows[i].res);

        for (int p = 0; p < N_GRIDS; p++) begin
            drain();
            apb_write(ADDR_WIDTH, grid_w[p]);
            apb_write(ADDR_HEIGHT, grid_h[p]);
            tx_gaps = (p != 4);
            rx_gaps = (p != 4);
            if (p == 2) hold_req = 1'b1;
            // finish the frame left open across the grid change
            repeat (tail_bytes) send_byte(8'($urandom_range(255)), 1'b0);
            tail_bytes = 0;
            goal = live_bytes + PHASE_BYTES;
            while (live_bytes < goal) begin
                if ($urandom_range(99) < 85) begin
                    send_file();
                end else begin
                    repeat ($urandom_range(1, 6))
                        send_byte(8'($urandom_range(255)), $urandom_range(99) < 10);
                end
            end
            if (p != N_GRIDS - 1) begin
                send_file_header(8'($urandom_range(255)));
                send_byte(8'($urandom_range(255)), 1'b0);
                send_byte(8'($urandom_range(255)), 1'b0);
                send_byte(8'd0, 1'b0);
                send_byte(8'd30, 1'b0);
                repeat (15) send_byte(8'($urandom_range(255)), 1'b0);
                tail_bytes = 15;
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0 && event_q.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/pfsp_pkg.sv
rtl/pfsp_front.sv
rtl/pfsp_queue.sv
rtl/pfsp_back.sv
rtl/pixel_frame_stream_parser.sv
sim/tb_top.sv
